### rtl/csvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV tokenizer package
// Shared types, register indexes, row modes and sizes of the CSV stream
// tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DELIMITER    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUOTE_CHAR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_BREAK   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COMMENT_CHAR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_LINES   = 3'd4;

	// Reset values of the registers.
	localparam logic [7:0]  RST_DELIMITER    = 8'd44;
	localparam logic [7:0]  RST_QUOTE_CHAR   = 8'd34;
	localparam logic [7:0]  RST_LINE_BREAK   = 8'd10;
	localparam logic [7:0]  RST_COMMENT_CHAR = 8'd59;
	localparam logic [15:0] RST_SKIP_LINES   = 16'd0;

	// Carriage return byte.
	localparam logic [7:0] CR_BYTE = 8'h0D;

	// Row modes.
	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_SKIP   = 2'd1;
	localparam logic [1:0] MODE_DROP   = 2'd2;

	// Result queue size.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0]  delimiter;
		logic [7:0]  quote_char;
		logic [7:0]  line_break;
		logic [7:0]  comment_char;
		logic [15:0] skip_lines;
	} cfg_t;

	typedef struct packed {
		logic        in_quotes;
		logic        skip_next;
		logic        at_field_start;
		logic        at_row_start;
		logic        first_quoted_pending;
		logic [1:0]  row_mode;
		logic        held_return;
		logic [15:0] lines_skipped;
		logic        finished;
	} st_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       field_end;
		logic       row_end;
		logic       was_quoted;
	} res_t;

	// Results of one byte: up to two, in order.
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} emit_t;

	// Tokenizer state after a row boundary.
	function automatic st_t new_row(input st_t s);
		st_t r;
		r = s;
		r.in_quotes            = 1'b0;
		r.skip_next            = 1'b0;
		r.at_field_start       = 1'b1;
		r.at_row_start         = 1'b1;
		r.first_quoted_pending = 1'b0;
		r.held_return          = 1'b0;
		return r;
	endfunction

endpackage

### rtl/csvt_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV tokenizer byte decoder
// Combinational next-state and result logic for one text byte.
// ----------------------------------------------------------------------------
module csvt_parse (
	input  csvt_pkg::cfg_t  cfg,
	input  csvt_pkg::st_t   st,
	input  logic [7:0]      in_byte,
	input  logic            end_of_input,
	output csvt_pkg::st_t   st_next,
	output csvt_pkg::emit_t emit
);
	import csvt_pkg::*;

	st_t         ns;
	res_t        hr;
	res_t        tr;
	logic        hv;
	logic        tv;
	logic        cont;
	logic        drop;
	logic [15:0] ls_inc;

	function automatic res_t mk_res(input logic [7:0] b, input logic v, input logic fe,
			input logic re, input logic q);
		res_t r;
		r.data_byte  = v ? b : 8'd0;
		r.byte_valid = v;
		r.field_end  = fe;
		r.row_end    = re;
		r.was_quoted = fe & q;
		return r;
	endfunction

	// Decode one byte against the current state.
	always_comb begin
		ns     = st;
		hv     = 1'b0;
		tv     = 1'b0;
		hr     = '0;
		tr     = '0;
		cont   = 1'b0;
		drop   = 1'b0;
		ls_inc = st.lines_skipped;
		if (st.finished) begin
			ns = st;
		end else if (end_of_input) begin
			if (st.row_mode == MODE_NORMAL) begin
				if (st.skip_next || st.in_quotes) begin
					tv = 1'b1;
					tr = mk_res(8'd0, 1'b0, 1'b1, 1'b1, 1'b1);
				end else if (st.at_row_start) begin
					if (st.held_return) begin
						tv = 1'b1;
						tr = mk_res(8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
					end
				end else begin
					tv = 1'b1;
					tr = mk_res(8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
				end
			end
			ns          = new_row(ns);
			ns.finished = 1'b1;
		end else if (st.row_mode != MODE_NORMAL) begin
			// Skipped or dropped line: track quote parity, end at an unquoted break.
			if (in_byte == cfg.quote_char) begin
				ns.in_quotes = !st.in_quotes;
			end else if (in_byte == cfg.line_break && !st.in_quotes) begin
				if (st.row_mode == MODE_SKIP) begin
					if (st.lines_skipped != 16'hFFFF) begin
						ls_inc = st.lines_skipped + 16'd1;
					end
					ns.lines_skipped = ls_inc;
					if (ls_inc >= cfg.skip_lines) begin
						ns.row_mode = MODE_NORMAL;
					end
				end else begin
					ns.row_mode = MODE_NORMAL;
				end
				ns = new_row(ns);
			end
		end else begin
			cont = 1'b1;
			// A held carriage return is resolved first.
			if (st.held_return) begin
				ns.held_return = 1'b0;
				hv = 1'b1;
				if (in_byte == cfg.line_break) begin
					if (st.skip_next) begin
						hr = mk_res(8'd0, 1'b0, 1'b1, 1'b1, 1'b1);
					end else if (st.at_row_start) begin
						hr = mk_res(8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
					end else begin
						hr = mk_res(8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
					end
					ns   = new_row(ns);
					cont = 1'b0;
				end else begin
					if (st.skip_next) begin
						hr                = mk_res(8'd0, 1'b0, 1'b1, 1'b0, 1'b1);
						ns.skip_next      = 1'b0;
						ns.at_field_start = 1'b1;
					end else begin
						hr                = mk_res(CR_BYTE, 1'b1, 1'b0, 1'b0, 1'b0);
						ns.at_field_start = 1'b0;
					end
					ns.at_row_start = 1'b0;
				end
			end else if (st.skip_next) begin
				// Byte after a closing quote.
				cont = 1'b0;
				if (in_byte == cfg.line_break) begin
					tv = 1'b1;
					tr = mk_res(8'd0, 1'b0, 1'b1, 1'b1, 1'b1);
					ns = new_row(ns);
				end else if (in_byte == CR_BYTE) begin
					ns.held_return = 1'b1;
				end else begin
					tv                = 1'b1;
					tr                = mk_res(8'd0, 1'b0, 1'b1, 1'b0, 1'b1);
					ns.skip_next      = 1'b0;
					ns.at_field_start = 1'b1;
					ns.at_row_start   = 1'b0;
				end
			end

			if (cont) begin
				if (ns.in_quotes) begin
					// Inside a quoted field only the quote is special, save a comment byte opening a row's first field.
					if (ns.first_quoted_pending) begin
						ns.first_quoted_pending = 1'b0;
						if (in_byte == cfg.comment_char && in_byte != cfg.quote_char) begin
							ns.row_mode = MODE_DROP;
							drop        = 1'b1;
						end
					end
					if (!drop) begin
						if (in_byte == cfg.quote_char) begin
							ns.in_quotes = 1'b0;
							ns.skip_next = 1'b1;
						end else begin
							tv = 1'b1;
							tr = mk_res(in_byte, 1'b1, 1'b0, 1'b0, 1'b0);
						end
					end
				end else if (in_byte == cfg.line_break) begin
					tv = 1'b1;
					if (ns.at_row_start) begin
						tr = mk_res(8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
					end else begin
						tr = mk_res(8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
					end
					ns = new_row(ns);
				end else if (ns.at_field_start && in_byte == cfg.quote_char) begin
					ns.in_quotes            = 1'b1;
					ns.first_quoted_pending = ns.at_row_start;
					ns.at_field_start       = 1'b0;
					ns.at_row_start         = 1'b0;
				end else if (in_byte == cfg.delimiter) begin
					tv                = 1'b1;
					tr                = mk_res(8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
					ns.at_field_start = 1'b1;
					ns.at_row_start   = 1'b0;
				end else if (ns.at_row_start && in_byte == cfg.comment_char) begin
					ns.row_mode  = MODE_DROP;
					ns.in_quotes = 1'b0;
				end else if (in_byte == CR_BYTE) begin
					ns.held_return = 1'b1;
				end else begin
					tv                = 1'b1;
					tr                = mk_res(in_byte, 1'b1, 1'b0, 1'b0, 1'b0);
					ns.at_field_start = 1'b0;
					ns.at_row_start   = 1'b0;
				end
			end
		end
	end

	// Pack the results in order: a resolved carriage return comes first.
	always_comb begin
		st_next = ns;
		if (hv) begin
			emit.count = tv ? 2'd2 : 2'd1;
			emit.r0    = hr;
			emit.r1    = tr;
		end else begin
			emit.count = tv ? 2'd1 : 2'd0;
			emit.r0    = tr;
			emit.r1    = tr;
		end
	end

endmodule

### rtl/csvt_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV tokenizer result queue
// Small queue that takes up to two results a cycle and hands out one per
// transfer on the output channel.
// ----------------------------------------------------------------------------
module csvt_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  csvt_pkg::emit_t emit,
	output logic            room,
	output logic            out_valid,
	input  logic            out_stall,
	output csvt_pkg::res_t  head
);
	import csvt_pkg::*;

	res_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [1:0]        push_n;
	logic              pop;
	logic [QPTR_W-1:0] wr_ptr_p1;

	assign push_n    = push ? emit.count : 2'd0;
	assign pop       = out_valid && !out_stall;
	assign wr_ptr_p1 = wr_ptr_q + QPTR_W'(1);
	// Room for a whole byte's worth of results, judged from the registered count.
	assign room      = count_q <= QCNT_W'(QDEPTH - 2);
	assign out_valid = count_q != '0;
	assign head      = entry_q[rd_ptr_q];

	// Result storage.
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			entry_q[wr_ptr_q] <= emit.r0;
		end
		if (push_n == 2'd2) begin
			entry_q[wr_ptr_p1] <= emit.r1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push_n) - QCNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> (count_q <= QCNT_W'(QDEPTH - 2)))
		else $error("result queue written without room");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("result queue count out of range");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd0 && !pop) |=> $stable(count_q))
		else $error("result queue count moved without a transfer");
`endif

endmodule

### rtl/csv_stream_tokenizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV stream tokenizer
// Splits CSV text, one byte per input transfer, into field bytes with
// field-end and row-end marks, honoring quoted fields, skipped leading lines
// and comment rows.
// ----------------------------------------------------------------------------
// The block takes one text byte per clock cycle while not stalled. Each
// accepted byte is held in an input register, decoded against the tokenizer
// flags and the configuration registers, and its results (none, one, or two
// when a held carriage return is resolved) go into a four-entry result queue.
// The output channel moves one result per cycle unless stalled, so sustained
// rate is one byte per cycle while a byte yields at most one result on
// average; the input is stalled while a byte is held and the queue has fewer
// than two free entries. The user must write configuration only while no byte
// is in flight and the result queue is empty; the block does not enforce it.
// ----------------------------------------------------------------------------
module csv_stream_tokenizer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port.
	input  logic                           cfg_we,
	input  logic [csvt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [csvt_pkg::CFG_DATA_W-1:0] cfg_data,
	// Input channel.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     in_byte,
	input  logic                           end_of_input,
	// Output channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     data_byte,
	output logic                           byte_valid,
	output logic                           field_end,
	output logic                           row_end,
	output logic                           was_quoted
);
	import csvt_pkg::*;

	cfg_t       cfg_q;
	st_t        st_q;
	st_t        st_next;
	st_t        st_cfg;
	emit_t      emit;
	res_t       head;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;
	logic       room;
	logic       advance;
	logic       in_xfer;
	logic [15:0] new_skip;

	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign in_xfer  = in_valid && !in_stall;
	assign new_skip = cfg_data[15:0];

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= in_byte;
			eoi_s1  <= end_of_input;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter    <= RST_DELIMITER;
			cfg_q.quote_char   <= RST_QUOTE_CHAR;
			cfg_q.line_break   <= RST_LINE_BREAK;
			cfg_q.comment_char <= RST_COMMENT_CHAR;
			cfg_q.skip_lines   <= RST_SKIP_LINES;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DELIMITER:    cfg_q.delimiter    <= cfg_data[7:0];
				REG_QUOTE_CHAR:   cfg_q.quote_char   <= cfg_data[7:0];
				REG_LINE_BREAK:   cfg_q.line_break   <= cfg_data[7:0];
				REG_COMMENT_CHAR: cfg_q.comment_char <= cfg_data[7:0];
				REG_SKIP_LINES:   cfg_q.skip_lines   <= new_skip;
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	// Effect of a new line skip count on the row mode.
	always_comb begin
		st_cfg = st_q;
		if (st_q.row_mode == MODE_SKIP && st_q.lines_skipped >= new_skip) begin
			st_cfg          = new_row(st_q);
			st_cfg.row_mode = MODE_NORMAL;
		end else if (st_q.row_mode == MODE_NORMAL && new_skip > st_q.lines_skipped &&
				st_q.at_row_start && !st_q.held_return && !st_q.in_quotes &&
				!st_q.skip_next) begin
			st_cfg.row_mode = MODE_SKIP;
		end
	end

	// Tokenizer state. After reset the tokenizer sits at a row start in normal mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= new_row(st_t'('0));
		end else if (cfg_we && cfg_index == REG_SKIP_LINES) begin
			st_q <= st_cfg;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	csvt_parse u_parse (
		.cfg          (cfg_q),
		.st           (st_q),
		.in_byte      (byte_s1),
		.end_of_input (eoi_s1),
		.st_next      (st_next),
		.emit         (emit)
	);

	csvt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.emit      (emit),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign data_byte  = head.data_byte;
	assign byte_valid = head.byte_valid;
	assign field_end  = head.field_end;
	assign row_end    = head.row_end;
	assign was_quoted = head.was_quoted;

`ifndef SYNTHESIS
	a_finished_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && st_q.finished) |-> (emit.count == 2'd0))
		else $error("result produced after end of input");

	a_finished_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.finished && !(cfg_we && cfg_index == REG_SKIP_LINES)) |=> st_q.finished)
		else $error("end of input state cleared");

	a_quoted_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit.count != 2'd0 && emit.r0.was_quoted) |-> emit.r0.field_end)
		else $error("quoted mark without field end");

	a_skip_quote: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.row_mode == MODE_NORMAL && st_q.skip_next) |-> !st_q.in_quotes)
		else $error("closing quote pending inside quotes");
`endif

endmodule

### tb/csv_stream_tokenizer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV stream tokenizer testbench
// Streams CSV text through the tokenizer under several delimiter, quote,
// line break, comment and skip settings. A parser model inside the testbench
// predicts every field byte, field end and row end, and each output transfer
// is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module csv_stream_tokenizer_core_tb;
	import csvt_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int GAP_PCT       = 37;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 200000;

	// One text transfer: a byte, or the end-of-text mark.
	typedef struct packed {
		logic [7:0] text;
		logic       last;
	} text_item_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic [7:0]            in_byte      = '0;
	logic                  end_of_input = 1'b0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic [7:0]            data_byte;
	logic                  byte_valid;
	logic                  field_end;
	logic                  row_end;
	logic                  was_quoted;

	// Parser model: settings and flags.
	logic [7:0]  sep_char, quote_byte, break_char, comment_byte;
	logic [15:0] skip_target, lines_done;
	logic [1:0]  parse_mode;
	logic        in_quotes, closed_quote, field_start, row_start;
	logic        quoted_first, held_cr, stream_done;

	res_t       expected_tokens [$];
	text_item_t pending_text [$];
	text_item_t sent_item;
	logic       gaps_on = 1'b1;
	int         errors  = 0;
	int         cycles  = 0;

	csv_stream_tokenizer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_byte    (data_byte),
		.byte_valid   (byte_valid),
		.field_end    (field_end),
		.row_end      (row_end),
		.was_quoted   (was_quoted)
	);

	always #5 clk = ~clk;

	// Record one predicted token; data and the quoted mark are zero when unused.
	function automatic void expect_token(logic [7:0] data, logic valid, logic fend,
			logic rend, logic quoted);
		res_t t;
		t.data_byte  = valid ? data : 8'h00;
		t.byte_valid = valid;
		t.field_end  = fend;
		t.row_end    = rend;
		t.was_quoted = fend & quoted;
		expected_tokens.insert(expected_tokens.size(), t);
	endfunction

	// Flags at the start of every row.
	function automatic void open_row();
		in_quotes    = 1'b0;
		closed_quote = 1'b0;
		field_start  = 1'b1;
		row_start    = 1'b1;
		quoted_first = 1'b0;
		held_cr      = 1'b0;
	endfunction

	function automatic void reset_parser();
		sep_char     = RST_DELIMITER;
		quote_byte   = RST_QUOTE_CHAR;
		break_char   = RST_LINE_BREAK;
		comment_byte = RST_COMMENT_CHAR;
		skip_target  = RST_SKIP_LINES;
		open_row();
		parse_mode   = MODE_NORMAL;
		lines_done   = '0;
		stream_done  = 1'b0;
	endfunction

	// Register write as seen by the parser model.
	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_DELIMITER:    sep_char = val[7:0];
			REG_QUOTE_CHAR:   quote_byte = val[7:0];
			REG_LINE_BREAK:   break_char = val[7:0];
			REG_COMMENT_CHAR: comment_byte = val[7:0];
			REG_SKIP_LINES: begin
				skip_target = val;
				if (parse_mode == MODE_SKIP && lines_done >= skip_target) begin
					parse_mode = MODE_NORMAL;
					open_row();
				end else if (parse_mode == MODE_NORMAL && skip_target > lines_done &&
						row_start && !held_cr && !in_quotes && !closed_quote) begin
					parse_mode = MODE_SKIP;
				end
			end
			default: ;
		endcase
	endfunction

	// Predict the tokens caused by one accepted text transfer.
	function automatic void tokenize_byte(logic [7:0] c, logic last);
		if (stream_done)
			return;

		// End of text closes the open row, if any.
		if (last) begin
			if (parse_mode == MODE_NORMAL) begin
				if (closed_quote || in_quotes)
					expect_token(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
				else if (row_start) begin
					if (held_cr)
						expect_token(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
				end else
					expect_token(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
			end
			open_row();
			stream_done = 1'b1;
			return;
		end

		// Skipped or dropped lines only track quote parity and the line end.
		if (parse_mode != MODE_NORMAL) begin
			if (c == quote_byte)
				in_quotes = !in_quotes;
			else if (c == break_char && !in_quotes) begin
				if (parse_mode == MODE_SKIP) begin
					if (lines_done != 16'hFFFF)
						lines_done = lines_done + 16'd1;
					if (lines_done >= skip_target)
						parse_mode = MODE_NORMAL;
				end else
					parse_mode = MODE_NORMAL;
				open_row();
			end
			return;
		end

		// A held carriage return is resolved by the byte after it.
		if (held_cr) begin
			held_cr = 1'b0;
			if (c == break_char) begin
				if (closed_quote)
					expect_token(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
				else if (row_start)
					expect_token(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
				else
					expect_token(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
				open_row();
				return;
			end
			if (closed_quote) begin
				expect_token(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
				closed_quote = 1'b0;
				field_start  = 1'b1;
			end else begin
				expect_token(CR_BYTE, 1'b1, 1'b0, 1'b0, 1'b0);
				field_start = 1'b0;
			end
			row_start = 1'b0;
		end else if (closed_quote) begin
			// The byte after a closing quote is consumed.
			if (c == break_char) begin
				expect_token(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
				open_row();
			end else if (c == CR_BYTE)
				held_cr = 1'b1;
			else begin
				expect_token(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
				closed_quote = 1'b0;
				field_start  = 1'b1;
				row_start    = 1'b0;
			end
			return;
		end

		// Inside quotes only the quote byte is special, save a comment byte opening a row's first field.
		if (in_quotes) begin
			if (quoted_first) begin
				quoted_first = 1'b0;
				if (c == comment_byte && c != quote_byte) begin
					parse_mode = MODE_DROP;
					return;
				end
			end
			if (c == quote_byte) begin
				in_quotes    = 1'b0;
				closed_quote = 1'b1;
			end else
				expect_token(c, 1'b1, 1'b0, 1'b0, 1'b0);
			return;
		end

		if (c == break_char) begin
			if (row_start)
				expect_token(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
			else
				expect_token(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
			open_row();
			return;
		end
		if (field_start && c == quote_byte) begin
			in_quotes    = 1'b1;
			quoted_first = row_start;
			field_start  = 1'b0;
			row_start    = 1'b0;
			return;
		end
		if (c == sep_char) begin
			expect_token(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
			field_start = 1'b1;
			row_start   = 1'b0;
			return;
		end
		if (row_start && c == comment_byte) begin
			parse_mode = MODE_DROP;
			in_quotes  = 1'b0;
			return;
		end
		if (c == CR_BYTE) begin
			held_cr = 1'b1;
			return;
		end
		expect_token(c, 1'b1, 1'b0, 1'b0, 1'b0);
		field_start = 1'b0;
		row_start   = 1'b0;
	endfunction

	// Text generation from the current settings.
	function automatic void push_text(logic [7:0] c);
		text_item_t t;
		t.text = c;
		t.last = 1'b0;
		pending_text.insert(pending_text.size(), t);
	endfunction

	// A byte with no special meaning under the current settings.
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do
			c = 8'($urandom);
		while (c == sep_char || c == quote_byte || c == break_char ||
				c == comment_byte || c == CR_BYTE);
		return c;
	endfunction

	// A well-formed row: a comment row, or plain and quoted fields.
	function automatic void add_row();
		int fields;
		int len;
		if ($urandom_range(9) == 0) begin
			push_text(comment_byte);
			repeat ($urandom_range(4)) push_text(plain_char());
			push_text(break_char);
			return;
		end
		fields = $urandom_range(4, 1);
		for (int f = 0; f < fields; f++) begin
			if (f != 0)
				push_text(sep_char);
			len = $urandom_range(5);
			if ($urandom_range(9) < 4) begin
				push_text(quote_byte);
				for (int i = 0; i < len; i++)
					case ($urandom_range(7))
						0: push_text(sep_char);
						1: push_text(break_char);
						2: push_text(CR_BYTE);
						default: push_text(plain_char());
					endcase
				push_text(quote_byte);
			end else begin
				for (int i = 0; i < len; i++)
					push_text(plain_char());
			end
		end
		if ($urandom_range(2) == 0)
			push_text(CR_BYTE);
		push_text(break_char);
	endfunction

	// A short burst biased toward the special bytes.
	function automatic void add_noise();
		repeat ($urandom_range(6, 1))
			case ($urandom_range(7))
				0: push_text(sep_char);
				1: push_text(quote_byte);
				2: push_text(break_char);
				3: push_text(comment_byte);
				4: push_text(CR_BYTE);
				default: push_text(8'($urandom));
			endcase
	endfunction

	function automatic void fill_text(int count);
		while (pending_text.size() < count)
			if ($urandom_range(4) == 0)
				add_noise();
			else
				add_row();
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Register writes keep the write enable high across back-to-back writes.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		apply_reg(idx, val);
	endtask

	// Character registers get random upper data bits.
	task automatic write_char(logic [CFG_IDX_W-1:0] idx, logic [7:0] c);
		write_reg(idx, {8'($urandom), c});
	endtask

	task automatic close_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until all text is sent and every predicted token has arrived.
	task automatic drain();
		while (pending_text.size() != 0 || in_valid || expected_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Input driver: predict on each accepted transfer, then offer the next item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tokenize_byte(sent_item.text, sent_item.last);
			if (!in_valid || !in_stall) begin
				if (pending_text.size() != 0 && !(gaps_on && $urandom_range(99) < GAP_PCT)) begin
					sent_item = pending_text.pop_front();
					in_valid     <= 1'b1;
					in_byte      <= sent_item.text;
					end_of_input <= sent_item.last;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Output monitor: compare each token transfer with the oldest prediction.
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_tokens.size() == 0) begin
					$display("%0t: unexpected token: expected none, actual %h %b%b%b%b", $time,
						data_byte, byte_valid, field_end, row_end, was_quoted);
					errors++;
				end else begin
					want = expected_tokens.pop_front();
					check_field("data_byte", want.data_byte, data_byte);
					check_field("byte_valid", 8'(want.byte_valid), 8'(byte_valid));
					check_field("field_end", 8'(want.field_end), 8'(field_end));
					check_field("row_end", 8'(want.row_end), 8'(row_end));
					check_field("was_quoted", 8'(want.was_quoted), 8'(was_quoted));
				end
			end
			out_stall <= gaps_on && ($urandom_range(99) < GAP_PCT);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [7:0] opening_text [$];
		text_item_t tail;
		reset_parser();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default settings: empty row, comment rows (one with a quoted line break),
		// a quoted first field that starts with the comment byte, extreme data
		// bytes, a quote inside a plain field, a carriage return before a row end,
		// a quoted field holding a delimiter and a line break, the byte after a
		// closing quote, a held carriage return that turns out to be data, and a
		// closing quote followed by a carriage return and a line break.
		opening_text = '{8'h0A,
			8'h3B, 8'h22, 8'h0A, 8'h22, 8'h0A,
			8'h22, 8'h3B, 8'h22, 8'h0A,
			8'h00, 8'h22, 8'hFF, 8'h0D, 8'h0A,
			8'h22, 8'h0A, 8'h2C, 8'h22, 8'h62, 8'h0D, 8'h7A, 8'h2C,
			8'h22, 8'h71, 8'h22, 8'h0D, 8'h0A};
		foreach (opening_text[i])
			push_text(opening_text[i]);
		fill_text(180);
		drain();

		// Semicolon separated text with single quotes and two header lines.
		write_char(REG_DELIMITER, 8'h3B);
		write_char(REG_QUOTE_CHAR, 8'h27);
		write_char(REG_LINE_BREAK, 8'h0A);
		write_char(REG_COMMENT_CHAR, 8'h23);
		write_reg(REG_SKIP_LINES, 16'd2);
		close_writes();
		fill_text(150);
		drain();

		// Extreme bytes, with the line break equal to carriage return and the
		// comment byte equal to the quote byte; no idle cycles on either side.
		gaps_on <= 1'b0;
		write_char(REG_DELIMITER, 8'h00);
		write_char(REG_QUOTE_CHAR, 8'hFF);
		write_char(REG_LINE_BREAK, CR_BYTE);
		write_char(REG_COMMENT_CHAR, 8'hFF);
		write_reg(REG_SKIP_LINES, 16'd0);
		close_writes();
		fill_text(120);
		drain();
		gaps_on <= 1'b1;

		// Largest skip count: the text is swallowed line by line.
		write_char(REG_DELIMITER, RST_DELIMITER);
		write_char(REG_QUOTE_CHAR, RST_QUOTE_CHAR);
		write_char(REG_LINE_BREAK, RST_LINE_BREAK);
		write_char(REG_COMMENT_CHAR, RST_COMMENT_CHAR);
		write_reg(REG_SKIP_LINES, 16'hFFFF);
		close_writes();
		fill_text(30);
		drain();

		// Skipping released, random and possibly colliding special bytes.
		write_reg(REG_SKIP_LINES, 16'd0);
		write_char(REG_DELIMITER, 8'($urandom));
		write_char(REG_QUOTE_CHAR, 8'($urandom));
		write_char(REG_LINE_BREAK, 8'($urandom));
		write_char(REG_COMMENT_CHAR, 8'($urandom));
		write_reg(REG_UNUSED, 16'($urandom));
		close_writes();
		fill_text(150);
		drain();

		// Defaults again, a few more lines to skip, then the end of the text.
		write_char(REG_DELIMITER, RST_DELIMITER);
		write_char(REG_QUOTE_CHAR, RST_QUOTE_CHAR);
		write_char(REG_LINE_BREAK, RST_LINE_BREAK);
		write_char(REG_COMMENT_CHAR, RST_COMMENT_CHAR);
		write_reg(REG_SKIP_LINES, lines_done + 16'd3);
		close_writes();
		fill_text(150);
		if ($urandom_range(1) == 0)
			add_noise();
		tail.text = 8'($urandom);
		tail.last = 1'b1;
		pending_text.insert(pending_text.size(), tail);
		// Transfers after the end of the text must produce nothing.
		repeat (3) begin
			tail.text = 8'($urandom);
			tail.last = 1'($urandom);
			pending_text.insert(pending_text.size(), tail);
		end
		drain();

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
